// File: design/bas_pkg.sv
// Shared types and codes of the bounded array set engine.
package bas_pkg;

    // Action codes carried on the input tuser
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_MERGE  = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_QUERY  = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_DUMP   = 3'd6
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_DUP     = 2'd2,
        STS_MISSING = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_EMIT,
        S_DUMP
    } t_state;

    localparam int unsigned IN_VALUE_W  = 32;
    localparam int unsigned SIZE_W      = 6;
    localparam int unsigned CFG_W       = 6;
    localparam int unsigned OUT_TDATA_W = 48;

    // One result word, handed from the sequencer to the output register
    typedef struct packed {
        t_status                 status;
        logic                    present;
        logic [SIZE_W-1:0]       set_size;
        logic [IN_VALUE_W-1:0]   out_value;
        logic                    out_valid;
        logic                    last;
    } t_result;

endpackage

// File: design/bas_mem.sv
// Entry store: one write port, one registered read port with enable.
module bas_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bas_seq.sv
// Sequencer with the shared compare unit: scans, updates and lists the store.
module bas_seq #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic [2:0]                             i_in_action,
    input  logic [bas_pkg::IN_VALUE_W-1:0]         i_in_value,
    output logic                                   o_in_ready,
    input  logic [bas_pkg::CFG_W-1:0]              i_cap,
    input  logic                                   i_out_free,
    output logic                                   o_load,
    output bas_pkg::t_result                       o_res,
    output logic                                   o_we,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_waddr,
    output logic [((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32)-1:0] o_wdata,
    output logic                                   o_re,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] o_raddr,
    input  logic [((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32)-1:0] i_rdata
);

    import bas_pkg::*;

    localparam int unsigned SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state          r_state, n_state;
    logic [2:0]      r_act, n_act;
    logic [SW-1:0]   r_val, n_val;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic            r_have, n_have;
    logic [AW-1:0]   r_hit, n_hit;
    t_status         r_status, n_status;

    logic [CW-1:0]   w_fill_m1;
    logic [CW-1:0]   w_idx_p1;
    logic [CW-1:0]   w_idx_m1;
    logic            w_issue;
    logic            w_match;
    logic            w_full;
    logic            w_dump_last;
    logic            w_in_lookup;
    logic [7:0]      w_cap_eff;

    assign w_fill_m1   = r_fill - 1'b1;
    assign w_idx_p1    = r_idx + 1'b1;
    assign w_idx_m1    = r_idx - 1'b1;
    assign w_issue     = (r_idx < r_fill);
    assign w_match     = (i_rdata == r_val);
    assign w_dump_last = (r_idx == w_fill_m1);
    assign w_cap_eff   = (8'(i_cap) > 8'(CAPACITY)) ? 8'(CAPACITY) : 8'(i_cap);
    assign w_full      = (8'(r_fill) >= w_cap_eff);
    assign w_in_lookup = (i_in_action == ACT_INSERT) || (i_in_action == ACT_MERGE) ||
                         (i_in_action == ACT_ERASE)  || (i_in_action == ACT_REMOVE) ||
                         (i_in_action == ACT_QUERY);
    assign o_in_ready  = (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (w_in_lookup) begin
                        n_state = (r_fill == '0) ? S_DECIDE : S_SCAN;
                    end else if (i_in_action == ACT_DUMP && r_fill != '0) begin
                        n_state = S_DUMP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if ((r_pend && w_match) || !w_issue) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((r_act == ACT_ERASE || r_act == ACT_REMOVE) && r_have) begin
                    n_state = S_MOVE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MOVE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_out_free && w_dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_act    = r_act;
        n_val    = r_val;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_have   = r_have;
        n_hit    = r_hit;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_fill[AW-1:0];
        o_wdata  = r_val;
        o_re     = 1'b0;
        o_raddr  = r_idx[AW-1:0];
        o_load   = 1'b0;
        o_res    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_action;
                    n_val    = i_in_value[SW-1:0];
                    n_have   = 1'b0;
                    n_status = STS_OK;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    if (i_in_action == ACT_CLEAR) begin
                        n_fill = '0;
                    end
                    // first listed entry is fetched right away
                    if (i_in_action == ACT_DUMP && r_fill != '0) begin
                        o_re    = 1'b1;
                        o_raddr = '0;
                    end
                end
            end
            S_SCAN: begin
                // issue one read and compare the previous one each cycle
                o_re   = w_issue;
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = w_idx_p1;
                end
                if (r_pend && w_match) begin
                    n_have = 1'b1;
                    n_hit  = w_idx_m1[AW-1:0];
                    n_pend = 1'b0;
                end
            end
            S_DECIDE: begin
                case (r_act)
                    ACT_INSERT: begin
                        if (w_full) begin
                            n_status = STS_FULL;
                        end else if (r_have) begin
                            n_status = STS_DUP;
                        end else begin
                            o_we   = 1'b1;
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    ACT_MERGE: begin
                        if (!r_have) begin
                            if (w_full) begin
                                n_status = STS_FULL;
                            end else begin
                                o_we   = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                    end
                    ACT_ERASE, ACT_REMOVE: begin
                        if (r_have) begin
                            // fetch the last entry to fill the hole
                            n_fill  = w_fill_m1;
                            o_re    = 1'b1;
                            o_raddr = w_fill_m1[AW-1:0];
                        end else if (r_act == ACT_ERASE) begin
                            n_status = STS_MISSING;
                        end
                    end
                    default: ;
                endcase
            end
            S_MOVE: begin
                o_we    = 1'b1;
                o_waddr = r_hit;
                o_wdata = i_rdata;
            end
            S_EMIT: begin
                o_load         = i_out_free;
                o_res.status   = r_status;
                o_res.present  = r_have;
                o_res.set_size = SIZE_W'(r_fill);
                o_res.last     = 1'b1;
            end
            S_DUMP: begin
                o_load          = i_out_free;
                o_res.status    = STS_OK;
                o_res.set_size  = SIZE_W'(r_fill);
                o_res.out_value = IN_VALUE_W'(i_rdata);
                o_res.out_valid = 1'b1;
                o_res.last      = w_dump_last;
                // fetch the next entry as this one leaves
                if (i_out_free && !w_dump_last) begin
                    n_idx   = w_idx_p1;
                    o_re    = 1'b1;
                    o_raddr = w_idx_p1[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_have   <= n_have;
        r_hit    <= n_hit;
        r_status <= n_status;
    end

endmodule

// File: design/bounded_array_set_engine.sv
// Bounded unordered set engine: top level with config and output registers.
// A word on the input stream carries an action (tuser) and a value (tdata). Insert, merge,
// erase, remove and query first scan the stored entries in order through one compare unit
// fed by the store's single read port, one entry per cycle. An erase or remove that hits
// also moves the last entry into the hole. A dump lists one entry per cycle while the
// output register is free; output stalls hold both a listing and the final result.
// The input is not ready while a word is in work, but a new word is taken while the last
// result still waits in the output register.
// The capacity register must only be written while the block is idle.
module bounded_array_set_engine #(
    parameter int unsigned CAPACITY    = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bas_pkg::IN_VALUE_W-1:0]     s_axis_tdata,  // [31:0] item_value
    input  logic [2:0]                         s_axis_tuser,  // [2:0] action
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] status, [2] present, [8:3] set_size, [40:9] out_value, [47:41] zero
    output logic [bas_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser,  // [0] out_valid
    output logic                               m_axis_tlast,
    // capacity register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bas_pkg::CFG_W-1:0]          i_cfg_data
);

    import bas_pkg::*;

    localparam int unsigned SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CFG_W-1:0] r_cap;
    logic             r_ovalid;
    t_result          r_ores;

    logic             w_out_free;
    logic             w_load;
    t_result          w_res;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [SW-1:0]    w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [SW-1:0]    w_rdata;

    // capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CFG_W'(32);
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    bas_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (SW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bas_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_in_value  (s_axis_tdata),
        .o_in_ready  (s_axis_tready),
        .i_cap       (r_cap),
        .i_out_free  (w_out_free),
        .o_load      (w_load),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // output register
    assign w_out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ores <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_ores.out_value, r_ores.set_size,
                            r_ores.present, r_ores.status};
    assign m_axis_tuser  = r_ores.out_valid;
    assign m_axis_tlast  = r_ores.last;

`ifndef SYNTHESIS
    // a result is never loaded over one that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded while output register busy");

    // only dump words carry an entry, and only a dump word may be non-final
    a_last_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_res.out_valid) |-> w_res.last)
        else $error("non-dump result without last");

    // listed entries carry ok status and no presence flag
    a_dump_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.out_valid) |-> (w_res.status == STS_OK && !w_res.present))
        else $error("dump result with status or present set");
`endif

endmodule

// File: dv/bas_checker.sv
// Scoreboard for the bounded array set engine: predicts each result word and compares it.
`timescale 1ns / 1ps

module bas_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream, observed
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [bas_pkg::IN_VALUE_W-1:0]  i_s_tdata,   // [31:0] item_value
    input  logic [2:0]                      i_s_tuser,   // [2:0] action
    // result stream, observed
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [2] present, [8:3] set_size, [40:9] out_value, [47:41] zero
    input  logic [bas_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tuser,   // [0] out_valid
    input  logic                            i_m_tlast,
    // capacity register write, observed
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [bas_pkg::CFG_W-1:0]       i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    import bas_pkg::*;

    localparam int unsigned SET_DEPTH = 32;

    // Shadow copy of the set and its capacity register
    logic [IN_VALUE_W-1:0] stored_values [SET_DEPTH];
    int unsigned           stored_count = 0;
    logic [CFG_W-1:0]      capacity_reg = 6'd32;

    t_result               expected_results [$];
    int                    mismatches = 0;

    // One result word; the size field is the fill after the action
    function automatic t_result pack_result(input t_status st, input logic pres,
                                            input logic [IN_VALUE_W-1:0] val,
                                            input logic listed, input logic fin);
        t_result r;
        r.status    = st;
        r.present   = pres;
        r.set_size  = stored_count[SIZE_W-1:0];
        r.out_value = val;
        r.out_valid = listed;
        r.last      = fin;
        return r;
    endfunction

    // Append one predicted word at the tail of the queue
    task automatic add_expected(input t_result r);
        expected_results = {expected_results, r};
    endtask

    // Apply one action to the shadow set and queue the words it must produce
    task automatic apply_set_action(input logic [2:0] act, input logic [IN_VALUE_W-1:0] v);
        int          hit;
        logic        is_full;
        t_status     st;
        int unsigned cap_eff;
        st      = STS_OK;
        hit     = -1;
        cap_eff = (capacity_reg > SET_DEPTH) ? SET_DEPTH : capacity_reg;
        case (act)
            ACT_DUMP: begin
                if (stored_count == 0) begin
                    add_expected(pack_result(STS_OK, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < stored_count; i++) begin
                        add_expected(pack_result(STS_OK, 1'b0, stored_values[i],
                                                 1'b1, i == stored_count - 1));
                    end
                end
            end
            ACT_CLEAR: begin
                stored_count = 0;
                add_expected(pack_result(STS_OK, 1'b0, '0, 1'b0, 1'b1));
            end
            ACT_INSERT, ACT_MERGE, ACT_ERASE, ACT_REMOVE, ACT_QUERY: begin
                // lookup in stored order, first hit wins
                for (int i = 0; i < stored_count; i++) begin
                    if (hit < 0 && stored_values[i] == v) hit = i;
                end
                is_full = stored_count >= cap_eff;
                if (act == ACT_INSERT || act == ACT_MERGE) begin
                    // merge of a present value is a no-op; full wins over duplicate
                    if (!(hit >= 0 && act == ACT_MERGE)) begin
                        if (is_full) begin
                            st = STS_FULL;
                        end else if (hit >= 0) begin
                            st = STS_DUP;
                        end else begin
                            stored_values[stored_count] = v;
                            stored_count++;
                        end
                    end
                end else if (act == ACT_ERASE || act == ACT_REMOVE) begin
                    // last entry fills the hole
                    if (hit >= 0) begin
                        stored_count--;
                        stored_values[hit] = stored_values[stored_count];
                    end else if (act == ACT_ERASE) begin
                        st = STS_MISSING;
                    end
                end
                add_expected(pack_result(st, hit >= 0, '0, 1'b0, 1'b1));
            end
            default: begin
                // unused code: no change, one plain word
                add_expected(pack_result(STS_OK, 1'b0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $time, what);
    endtask

    // Watch all three channels at each edge
    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) capacity_reg = i_cfg_data;

            if (i_m_tvalid && i_m_tready) begin
                got.status    = t_status'(i_m_tdata[1:0]);
                got.present   = i_m_tdata[2];
                got.set_size  = i_m_tdata[8:3];
                got.out_value = i_m_tdata[40:9];
                got.out_valid = i_m_tuser;
                got.last      = i_m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word: tdata=%h tuser=%b tlast=%b",
                                              i_m_tdata, i_m_tuser, i_m_tlast));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.present !== want.present ||
                        got.set_size !== want.set_size || got.out_value !== want.out_value ||
                        got.out_valid !== want.out_valid || got.last !== want.last ||
                        i_m_tdata[47:41] !== '0) begin
                        report_mismatch($sformatf({"result mismatch: expected st=%0d pr=%0d ",
                            "size=%0d val=%h ov=%0d last=%0d pad=0, got st=%0d pr=%0d size=%0d ",
                            "val=%h ov=%0d last=%0d pad=%h"},
                            want.status, want.present, want.set_size, want.out_value,
                            want.out_valid, want.last, got.status, got.present, got.set_size,
                            got.out_value, got.out_valid, got.last, i_m_tdata[47:41]));
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) apply_set_action(i_s_tuser, i_s_tdata);
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

// File: dv/tb_bounded_array_set_engine.sv
// Testbench top for the set engine: stimulus, stall control, watchdog and verdict.
`timescale 1ns / 1ps

module tb_bounded_array_set_engine;
    import bas_pkg::*;

    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int POOL_SIZE        = 40;
    localparam int PHASE_WORDS      = 46;
    localparam int NUM_PHASES       = 6;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 5000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_VALUE_W-1:0]  s_tdata   = '0;
    logic [2:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;

    int fail_count;
    int pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_request       = 0;
    int idle_cycles        = 0;

    logic [IN_VALUE_W-1:0] value_pool [POOL_SIZE];

    // Per-phase capacity and idling
    int unsigned phase_cap        [NUM_PHASES] = '{63, 32, 8, 2, 32, 17};
    int          phase_send_idle  [NUM_PHASES] = '{0, 72, 0, 37, 0, 37};
    int          phase_recv_stall [NUM_PHASES] = '{0, 0, 72, 37, 0, 37};

    bounded_array_set_engine u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    bas_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin : result_sink
        int held;
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0 && !hold_taken) begin
                held       = hold_request;
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end else begin
                m_tready <= (receiver_stall_pct == 0) ||
                            ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_bounded_array_set_engine NOT OK");
                $finish;
            end
        end
    end

    // Offer one word, with random idle gaps before it; returns at the accepting edge
    task automatic send_word(input logic [2:0] act, input logic [IN_VALUE_W-1:0] val);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 3'($urandom_range(7, 0));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
    endtask

    // Stop offering and wait until every expected word is back and the block settles
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main stimulus
    initial begin
        int                    pick;
        logic [2:0]            act;
        logic [IN_VALUE_W-1:0] val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every action and the corner cases at reset capacity
        send_word(ACT_DUMP, 32'h0);                // empty set listing
        send_word(ACT_QUERY, 32'h0);
        send_word(ACT_INSERT, 32'h0);
        send_word(ACT_INSERT, 32'hFFFF_FFFF);
        send_word(ACT_INSERT, 32'h0);              // duplicate
        send_word(ACT_MERGE, 32'h0);               // already present, no change
        send_word(ACT_MERGE, 32'h1234_5678);
        send_word(ACT_QUERY, 32'hFFFF_FFFF);
        send_word(ACT_DUMP, 32'hFFFF_FFFF);
        send_word(ACT_ERASE, 32'h0);               // last entry moves into the hole
        send_word(ACT_ERASE, 32'h0);               // not found
        send_word(ACT_REMOVE, 32'h0);              // absent, still ok
        send_word(ACT_REMOVE, 32'hFFFF_FFFF);
        send_word(ACT_UNUSED, 32'hA5A5_A5A5);
        send_word(ACT_DUMP, 32'h0);
        send_word(ACT_CLEAR, 32'hFFFF_FFFF);

        // Capacity of one: full beats duplicate
        wait_idle();
        write_capacity(6'd1);
        send_word(ACT_INSERT, 32'h0000_000A);
        send_word(ACT_INSERT, 32'h0000_000B);      // full
        send_word(ACT_MERGE, 32'h0000_000B);       // full
        send_word(ACT_INSERT, 32'h0000_000A);      // full, not duplicate
        send_word(ACT_MERGE, 32'h0000_000A);       // present, ok

        // Capacity of zero below the current fill
        wait_idle();
        write_capacity(6'd0);
        send_word(ACT_INSERT, 32'h0000_000C);
        send_word(ACT_MERGE, 32'h0000_000C);
        send_word(ACT_QUERY, 32'h0000_000A);

        // Random phases: mostly pool values so lookups hit
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            write_capacity(phase_cap[ph][CFG_W-1:0]);
            sender_idle_pct    = phase_send_idle[ph];
            receiver_stall_pct = phase_recv_stall[ph];
            for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
            value_pool[0] = '0;
            value_pool[1] = '1;
            // long result hold-off while words keep coming
            if (ph == 4) hold_request = LONG_HOLD_CYCLES;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99, 0);
                val  = ($urandom_range(99, 0) < 85) ? value_pool[$urandom_range(POOL_SIZE - 1, 0)]
                                                     : $urandom;
                if (pick < 25)      act = ACT_INSERT;
                else if (pick < 45) act = ACT_MERGE;
                else if (pick < 57) act = ACT_ERASE;
                else if (pick < 67) act = ACT_REMOVE;
                else if (pick < 80) act = ACT_QUERY;
                else if (pick < 88) act = ACT_DUMP;
                else if (pick < 91) act = ACT_CLEAR;
                else if (pick < 94) act = ACT_UNUSED;
                else begin
                    act = 3'($urandom_range(7, 0));
                    val = $urandom;
                end
                send_word(act, val);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_bounded_array_set_engine OK");
        end else begin
            $display("tb_bounded_array_set_engine NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
design/bas_pkg.sv
design/bas_mem.sv
design/bas_seq.sv
design/bounded_array_set_engine.sv
dv/bas_checker.sv
dv/tb_bounded_array_set_engine.sv
